// ----- src/ecd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared widths, types and helpers of the elastic disc collision unit.
// ----------------------------------------------------------------------------
package ecd_pkg;

	localparam int QW    = 36;
	localparam int NW    = 117;
	localparam int DW    = 84;
	localparam int LANES = 4;

	localparam logic        NUDGE_IDX   = 1'b0;
	localparam logic [19:0] NUDGE_RESET = 20'd327680;

	typedef logic [NW-1:0] num_t;
	typedef logic [DW-1:0] den_t;
	typedef logic [QW-1:0] quo_t;

	typedef struct packed {
		logic [15:0]        m1;
		logic [15:0]        m2;
		logic signed [31:0] v1x;
		logic signed [31:0] v1y;
		logic signed [31:0] v2x;
		logic signed [31:0] v2y;
		logic signed [31:0] x1x;
		logic signed [31:0] x1y;
		logic signed [31:0] x2x;
		logic signed [31:0] x2y;
	} body_t;

	// lanes: 0 first x, 1 first y, 2 second x, 3 second y
	typedef struct packed {
		logic signed [31:0] v1x;
		logic signed [31:0] v1y;
		logic signed [31:0] v2x;
		logic signed [31:0] v2y;
		logic signed [31:0] p1x;
		logic signed [31:0] p1y;
		logic               eq;
		logic               coin;
		logic [LANES-1:0]   neg;
	} side_t;

	function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
		if (v > 38'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -38'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

// ----- src/ecd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_front
// Seven stages: differences, products, dot and squared distance, and the
// numerators and shared denominator of the four velocity corrections.
// ----------------------------------------------------------------------------
module ecd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  ecd_pkg::body_t      body,
	input  logic [19:0]         nudge,
	output logic                out_vld,
	output ecd_pkg::num_t       num [ecd_pkg::LANES],
	output ecd_pkg::den_t       den,
	output ecd_pkg::side_t      side
);

	logic [7:1] vld_s;

	// stage 1
	logic signed [32:0] dxx_c, dxy_c, dvx_c, dvy_c;
	logic signed [37:0] x1x_w, x1y_w, nd_w, px_c, py_c;
	logic               eq_c;
	logic signed [32:0] dxx_s1, dxy_s1, dvx_s1, dvy_s1;
	logic [15:0]        m1_s1, m2_s1;
	ecd_pkg::side_t     side_s1;

	assign dxx_c = 33'(body.x1x) - 33'(body.x2x);
	assign dxy_c = 33'(body.x1y) - 33'(body.x2y);
	assign dvx_c = 33'(body.v1x) - 33'(body.v2x);
	assign dvy_c = 33'(body.v1y) - 33'(body.v2y);
	assign eq_c  = (body.m1 == body.m2);
	assign x1x_w = 38'(body.x1x);
	assign x1y_w = 38'(body.x1y);
	assign nd_w  = signed'({18'b0, nudge});
	assign px_c  = eq_c ? x1x_w : ((body.x1x < body.x2x) ? x1x_w - nd_w : x1x_w + nd_w);
	assign py_c  = eq_c ? x1y_w : ((body.x1y < body.x2y) ? x1y_w - nd_w : x1y_w + nd_w);

	always_ff @(posedge clk) begin
		if (en) begin
			dxx_s1       <= dxx_c;
			dxy_s1       <= dxy_c;
			dvx_s1       <= dvx_c;
			dvy_s1       <= dvy_c;
			m1_s1        <= body.m1;
			m2_s1        <= body.m2;
			side_s1.v1x  <= body.v1x;
			side_s1.v1y  <= body.v1y;
			side_s1.v2x  <= body.v2x;
			side_s1.v2y  <= body.v2y;
			side_s1.p1x  <= ecd_pkg::sat32(px_c);
			side_s1.p1y  <= ecd_pkg::sat32(py_c);
			side_s1.eq   <= eq_c;
			side_s1.coin <= 1'b0;
			side_s1.neg  <= '0;
		end
	end

	// stage 2
	logic [32:0]        axx_c, axy_c;
	logic signed [65:0] pdx_s2, pdy_s2;
	logic [65:0]        sqx_s2, sqy_s2;
	logic [32:0]        ax_s2, ay_s2;
	logic               sgnx_s2, sgny_s2;
	logic [15:0]        m1_s2, m2_s2;
	ecd_pkg::side_t     side_c2;
	ecd_pkg::side_t     side_s2;

	assign axx_c = dxx_s1[32] ? (~dxx_s1 + 33'd1) : dxx_s1;
	assign axy_c = dxy_s1[32] ? (~dxy_s1 + 33'd1) : dxy_s1;

	always_comb begin
		side_c2      = side_s1;
		side_c2.coin = (dxx_s1 == '0) && (dxy_s1 == '0) && !side_s1.eq;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pdx_s2       <= 66'(dvx_s1) * 66'(dxx_s1);
			pdy_s2       <= 66'(dvy_s1) * 66'(dxy_s1);
			sqx_s2       <= 66'(axx_c) * 66'(axx_c);
			sqy_s2       <= 66'(axy_c) * 66'(axy_c);
			ax_s2        <= axx_c;
			ay_s2        <= axy_c;
			sgnx_s2      <= dxx_s1[32];
			sgny_s2      <= dxy_s1[32];
			m1_s2        <= m1_s1;
			m2_s2        <= m2_s1;
			side_s2      <= side_c2;
		end
	end

	// stage 3
	logic signed [66:0] dot_c;
	logic [66:0]        absdot_s3, d2_s3;
	logic [32:0]        ax_s3, ay_s3;
	logic [16:0]        msum_s3, f1_s3, f2_s3;
	ecd_pkg::side_t     side_c3;
	ecd_pkg::side_t     side_s3;

	assign dot_c = 67'(pdx_s2) + 67'(pdy_s2);

	always_comb begin
		side_c3     = side_s2;
		side_c3.neg = {dot_c[66] ^ sgny_s2, dot_c[66] ^ sgnx_s2,
			dot_c[66] ^ sgny_s2, dot_c[66] ^ sgnx_s2};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			absdot_s3   <= dot_c[66] ? (~dot_c + 67'd1) : dot_c;
			d2_s3       <= 67'(sqx_s2) + 67'(sqy_s2);
			ax_s3       <= ax_s2;
			ay_s3       <= ay_s2;
			msum_s3     <= 17'(m1_s2) + 17'(m2_s2);
			f1_s3       <= {m1_s2, 1'b0};
			f2_s3       <= {m2_s2, 1'b0};
			side_s3     <= side_c3;
		end
	end

	// stage 4
	logic [66:0]          plx_s4, phx_s4, ply_s4, phy_s4;
	ecd_pkg::den_t        den_s4;
	logic [16:0]          f1_s4, f2_s4;
	ecd_pkg::side_t       side_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			plx_s4  <= 67'(absdot_s3[33:0]) * 67'(ax_s3);
			phx_s4  <= 67'(absdot_s3[66:34]) * 67'(ax_s3);
			ply_s4  <= 67'(absdot_s3[33:0]) * 67'(ay_s3);
			phy_s4  <= 67'(absdot_s3[66:34]) * 67'(ay_s3);
			den_s4  <= ecd_pkg::DW'(d2_s3) * ecd_pkg::DW'(msum_s3);
			f1_s4   <= f1_s3;
			f2_s4   <= f2_s3;
			side_s4 <= side_s3;
		end
	end

	// stage 5
	logic [99:0]    tx_s5, ty_s5;
	ecd_pkg::den_t  den_s5;
	logic [16:0]    f1_s5, f2_s5;
	ecd_pkg::side_t side_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s5   <= 100'(plx_s4) + 100'({phx_s4, 34'b0});
			ty_s5   <= 100'(ply_s4) + 100'({phy_s4, 34'b0});
			den_s5  <= den_s4;
			f1_s5   <= f1_s4;
			f2_s5   <= f2_s4;
			side_s5 <= side_s4;
		end
	end

	// stages 6 and 7
	logic [66:0]    plo_s6 [ecd_pkg::LANES];
	logic [66:0]    phi_s6 [ecd_pkg::LANES];
	ecd_pkg::num_t  num_s7 [ecd_pkg::LANES];
	ecd_pkg::den_t  den_s6, den_s7;
	ecd_pkg::side_t side_s6, side_s7;

	for (genvar l = 0; l < ecd_pkg::LANES; l++) begin : g_lane
		logic [99:0] t_c;
		logic [16:0] f_c;

		assign t_c = (l % 2 == 0) ? tx_s5 : ty_s5;
		assign f_c = (l < 2) ? f2_s5 : f1_s5;

		always_ff @(posedge clk) begin
			if (en) begin
				plo_s6[l] <= 67'(t_c[49:0]) * 67'(f_c);
				phi_s6[l] <= 67'(t_c[99:50]) * 67'(f_c);
				num_s7[l] <= ecd_pkg::NW'(plo_s6[l]) + {phi_s6[l], 50'b0};
			end
		end

		assign num[l] = num_s7[l];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s6  <= den_s5;
			den_s7  <= den_s6;
			side_s6 <= side_s5;
			side_s7 <= side_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[6:1], in_vld};
		end
	end

	assign out_vld = vld_s[7];
	assign den     = den_s7;
	assign side    = side_s7;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_vld && en) |=> vld_s[1])
		else $error("accepted transfer did not enter stage 1");

endmodule

// ----- src/ecd_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_div
// Pipelined restoring divider: one quotient bit per stage, four numerators
// over one shared denominator, side data carried alongside.
// ----------------------------------------------------------------------------
module ecd_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  ecd_pkg::num_t  num [ecd_pkg::LANES],
	input  ecd_pkg::den_t  den,
	input  ecd_pkg::side_t side_in,
	output logic           out_vld,
	output ecd_pkg::quo_t  quo [ecd_pkg::LANES],
	output ecd_pkg::side_t side_out
);

	localparam int QW = ecd_pkg::QW;
	localparam int DW = ecd_pkg::DW;
	localparam int NW = ecd_pkg::NW;

	logic [DW-1:0]  rem_s  [QW][ecd_pkg::LANES];
	logic [QW-1:0]  nq_s   [QW][ecd_pkg::LANES];
	ecd_pkg::den_t  den_s  [QW];
	ecd_pkg::side_t side_s [QW];
	logic [QW-1:0]  vld_s;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		ecd_pkg::den_t  den_c;
		ecd_pkg::side_t side_c;
		logic           vld_c;

		if (k == 0) begin : g_first
			assign den_c  = den;
			assign side_c = side_in;
			assign vld_c  = in_vld;
		end else begin : g_next
			assign den_c  = den_s[k-1];
			assign side_c = side_s[k-1];
			assign vld_c  = vld_s[k-1];
		end

		for (genvar l = 0; l < ecd_pkg::LANES; l++) begin : g_lane
			logic [DW-1:0] rem_c;
			logic [QW-1:0] nq_c;
			logic [DW:0]   t_c;
			logic          ge_c;

			if (k == 0) begin : g_first
				assign rem_c = DW'(num[l][NW-1:QW]);
				assign nq_c  = num[l][QW-1:0];
			end else begin : g_next
				assign rem_c = rem_s[k-1][l];
				assign nq_c  = nq_s[k-1][l];
			end

			assign t_c  = {rem_c, nq_c[QW-1]};
			assign ge_c = (t_c >= {1'b0, den_c});

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= ge_c ? DW'(t_c - {1'b0, den_c}) : t_c[DW-1:0];
					nq_s[k][l]  <= {nq_c[QW-2:0], ge_c};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k]  <= den_c;
				side_s[k] <= side_c;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_c;
			end
		end
	end

	for (genvar l = 0; l < ecd_pkg::LANES; l++) begin : g_out
		assign quo[l] = nq_s[QW-1][l];
	end

	assign out_vld  = vld_s[QW-1];
	assign side_out = side_s[QW-1];

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld && !side_out.eq && !side_out.coin) |->
		(quo[0][QW-1] == 1'b0 && quo[1][QW-1] == 1'b0 &&
		 quo[2][QW-1] == 1'b0 && quo[3][QW-1] == 1'b0))
		else $error("correction quotient out of range");

endmodule

// ----- src/elastic_disc_collision_2d_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elastic_disc_collision_2d_unit
// Two-disc elastic collision in Q16.16 with saturated results and a
// configurable position nudge.
//
//   channel  handshake                    payload
//   item     item_valid / item_stall      masses, velocities, positions
//   result   result_valid / result_stall  new velocities, position, flag
//   config   APB write/read               nudge_distance at byte 0
//
// One item per cycle while the output is not stalled: 7 front stages, 36 divider
// stages (one quotient bit each), one output stage.
// Reset clears all valid bits and loads nudge_distance with 5.0.
// A stalled output register freezes the whole pipeline; item_stall follows.
// ----------------------------------------------------------------------------
module elastic_disc_collision_2d_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [15:0]        first_mass,
	input  logic [15:0]        second_mass,
	input  logic signed [31:0] first_vel_x,
	input  logic signed [31:0] first_vel_y,
	input  logic signed [31:0] second_vel_x,
	input  logic signed [31:0] second_vel_y,
	input  logic signed [31:0] first_pos_x,
	input  logic signed [31:0] first_pos_y,
	input  logic signed [31:0] second_pos_x,
	input  logic signed [31:0] second_pos_y,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] new_first_vel_x,
	output logic signed [31:0] new_first_vel_y,
	output logic signed [31:0] new_second_vel_x,
	output logic signed [31:0] new_second_vel_y,
	output logic signed [31:0] new_first_pos_x,
	output logic signed [31:0] new_first_pos_y,
	output logic               coincident_flag
);

	logic        en;
	logic [19:0] nudge_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nudge_q <= ecd_pkg::NUDGE_RESET;
		end else if (cfg_wr && paddr[2] == ecd_pkg::NUDGE_IDX) begin
			nudge_q <= pwdata[19:0];
		end
	end

	assign prdata = (paddr[2] == ecd_pkg::NUDGE_IDX) ? {12'b0, nudge_q} : '0;

	assign en         = !result_valid || !result_stall;
	assign item_stall = !en;

	ecd_pkg::body_t body;
	assign body = '{m1: first_mass, m2: second_mass,
		v1x: first_vel_x, v1y: first_vel_y, v2x: second_vel_x, v2y: second_vel_y,
		x1x: first_pos_x, x1y: first_pos_y, x2x: second_pos_x, x2y: second_pos_y};

	logic           fr_vld;
	ecd_pkg::num_t  fr_num [ecd_pkg::LANES];
	ecd_pkg::den_t  fr_den;
	ecd_pkg::side_t fr_side;

	ecd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (item_valid),
		.body    (body),
		.nudge   (nudge_q),
		.out_vld (fr_vld),
		.num     (fr_num),
		.den     (fr_den),
		.side    (fr_side)
	);

	logic           dv_vld;
	ecd_pkg::quo_t  dv_quo [ecd_pkg::LANES];
	ecd_pkg::side_t dv_side;

	ecd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (fr_vld),
		.num      (fr_num),
		.den      (fr_den),
		.side_in  (fr_side),
		.out_vld  (dv_vld),
		.quo      (dv_quo),
		.side_out (dv_side)
	);

	logic signed [37:0] corr [ecd_pkg::LANES];

	for (genvar l = 0; l < ecd_pkg::LANES; l++) begin : g_corr
		logic signed [37:0] q_c;
		assign q_c     = signed'({2'b0, dv_quo[l]});
		assign corr[l] = dv_side.neg[l] ? -q_c : q_c;
	end

	logic signed [31:0] v1x_c, v1y_c, v2x_c, v2y_c;

	always_comb begin
		priority if (dv_side.eq) begin
			v1x_c = dv_side.v2x;
			v1y_c = dv_side.v2y;
			v2x_c = dv_side.v1x;
			v2y_c = dv_side.v1y;
		end else if (dv_side.coin) begin
			v1x_c = dv_side.v1x;
			v1y_c = dv_side.v1y;
			v2x_c = dv_side.v2x;
			v2y_c = dv_side.v2y;
		end else begin
			v1x_c = ecd_pkg::sat32(38'(dv_side.v1x) - corr[0]);
			v1y_c = ecd_pkg::sat32(38'(dv_side.v1y) - corr[1]);
			v2x_c = ecd_pkg::sat32(38'(dv_side.v2x) + corr[2]);
			v2y_c = ecd_pkg::sat32(38'(dv_side.v2y) + corr[3]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			new_first_vel_x  <= v1x_c;
			new_first_vel_y  <= v1y_c;
			new_second_vel_x <= v2x_c;
			new_second_vel_y <= v2y_c;
			new_first_pos_x  <= dv_side.p1x;
			new_first_pos_y  <= dv_side.p1y;
			coincident_flag  <= dv_side.coin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= dv_vld;
		end
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("input stalled without a blocked output");

	a_nudge_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && paddr[2] == ecd_pkg::NUDGE_IDX) |=> (nudge_q == $past(pwdata[19:0])))
		else $error("nudge register write lost");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall && fr_vld) |=> fr_vld)
		else $error("pipeline transfer dropped during stall");

endmodule
